// ===== sv/priority_notification_queue_assert.svh =====
// Assertion macros for the priority notification queue
`ifndef PRIORITY_NOTIFICATION_QUEUE_ASSERT_SVH
`define PRIORITY_NOTIFICATION_QUEUE_ASSERT_SVH

// Condition holds at every clock edge out of reset
`define PNQ_ASSERT(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("pnq: invariant violated");

// Same-cycle implication
`define PNQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pnq: implication violated");

// Next-cycle implication
`define PNQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pnq: next-cycle implication violated");

`endif

// ===== sv/pnq_pkg.sv =====
// Shared constants and types for the priority notification queue
package pnq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_WIDTH   = 16;
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int LIMIT_W     = 17;  // 120 * 1000 fits

  localparam logic [7:0] MAX_DUR_S = 8'd120;
  localparam logic [9:0] MS_PER_S  = 10'd1000;

  localparam logic [1:0] PRI_AMBIENT = 2'd0;
  localparam logic [1:0] PRI_ALERT   = 2'd3;

  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam logic [1:0] ST_QUEUED  = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NONE    = 2'd3;

  typedef struct packed {
    logic [1:0]           pri;
    logic [6:0]           dur;
    logic [TAG_WIDTH-1:0] tag;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     front;  // insert at the head regardless of priority
  } cell_ctl_t;

endpackage

// ===== sv/pnq_in_if.sv =====
// Input channel: one command word per handshake
interface pnq_in_if import pnq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           operation;
  logic [1:0]           priority_req;
  logic [7:0]           duration_s;
  logic [TAG_WIDTH-1:0] content_tag;
  logic [31:0]          now_ms;

  modport source (output valid, operation, priority_req, duration_s, content_tag, now_ms,
                  input ready);
  modport sink   (input valid, operation, priority_req, duration_s, content_tag, now_ms,
                  output ready);
endinterface

// ===== sv/pnq_out_if.sv =====
// Output channel: one status word per command
interface pnq_out_if import pnq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           enqueue_status;
  logic                 active_valid;
  logic [1:0]           active_priority;
  logic [TAG_WIDTH-1:0] active_tag;
  logic [6:0]           active_duration_s;
  logic [COUNT_W-1:0]   queue_count;

  modport source (output valid, enqueue_status, active_valid, active_priority, active_tag,
                         active_duration_s, queue_count,
                  input ready);
  modport sink   (input valid, enqueue_status, active_valid, active_priority, active_tag,
                        active_duration_s, queue_count,
                  output ready);
endinterface

// ===== sv/priority_notification_queue.sv =====
// Priority notification queue: sorted chain of slots plus one active slot
//
//  channel | dir | words                         | accepted when
//  in_i    | in  | command (enqueue/tick/clear)  | in_i.valid && in_i.ready
//  out_o   | out | status after each command     | out_o.valid && out_o.ready
//
// Enqueue and clear go from accept through EXEC and RESULT to the output register; alert enqueue
// adds ALERT2 and tick adds TICK (alert shifts the chain twice; tick registers duration*1000 before the compare).
// A new command is taken only when the previous one has reached the output register,
// so a stalled output holds the block with one word waiting and the next one done.
// Reset clears the count and active slot; slot contents need no reset.
module priority_notification_queue import pnq_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  pnq_in_if.sink   in_i,
  pnq_out_if.source out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ALERT2,
    S_TICK,
    S_RESULT
  } state_e;

  state_e               state_q;
  logic [1:0]           op_q;
  entry_t               ent_in_q;
  logic [31:0]          now_q;
  logic [LIMIT_W-1:0]   limit_q;
  logic [1:0]           status_q;
  logic [COUNT_W-1:0]   count_q;
  logic                 shown_valid_q;
  entry_t               shown_q;
  logic [31:0]          start_q;

  logic                 out_valid_q;
  logic [1:0]           out_status_q;
  logic                 out_act_valid_q;
  entry_t               out_ent_q;
  logic [COUNT_W-1:0]   out_count_q;

  cell_ctl_t            ctl;
  logic [1:0]           enq_status;
  logic                 ambient_blocked;
  logic                 expired;
  logic                 promote;
  logic [6:0]           in_dur;
  entry_t               cell_ent [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] goes;

  // ---- slot chain ----
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    entry_t left_ent, right_ent;
    logic   left_goes, occ;

    assign occ = COUNT_W'(g) < count_q;

    if (g == 0) begin : g_head
      assign left_ent  = ent_in_q;
      assign left_goes = 1'b0;
    end else begin : g_body
      assign left_ent  = cell_ent[g-1];
      assign left_goes = goes[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign right_ent = cell_ent[g];
    end else begin : g_inner
      assign right_ent = cell_ent[g+1];
    end

    pnq_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .occupied_i  (occ),
      .new_i       (ent_in_q),
      .left_i      (left_ent),
      .left_goes_i (left_goes),
      .right_i     (right_ent),
      .ent_o       (cell_ent[g]),
      .goes_o      (goes[g])
    );
  end

  // ---- command decode ----
  assign in_dur = (in_i.duration_s > MAX_DUR_S) ? MAX_DUR_S[6:0] : in_i.duration_s[6:0];

  // sorted queue: head has the highest waiting priority
  assign ambient_blocked = (shown_valid_q && (shown_q.pri != PRI_AMBIENT)) ||
                           ((count_q != '0) && (cell_ent[0].pri != PRI_AMBIENT));

  assign expired = shown_valid_q && ((now_q - start_q) >= {{(32-LIMIT_W){1'b0}}, limit_q});
  assign promote = (!shown_valid_q || expired) && (count_q != '0);

  always_comb begin
    ctl        = '{op: CELL_HOLD, front: 1'b0};
    enq_status = ST_QUEUED;
    case (state_q)
      S_EXEC: begin
        if (op_q == OP_ENQUEUE) begin
          if ((ent_in_q.pri == PRI_AMBIENT) && ambient_blocked) begin
            enq_status = ST_DROPPED;
          end else if (ent_in_q.pri == PRI_ALERT) begin
            if (count_q > COUNT_W'(QUEUE_DEPTH - 2)) begin
              enq_status = ST_FULL;
            end else begin
              ctl = '{op: CELL_INSERT, front: 1'b1};
            end
          end else if (count_q == COUNT_W'(QUEUE_DEPTH)) begin
            enq_status = ST_FULL;
          end else begin
            ctl = '{op: CELL_INSERT, front: 1'b0};
          end
        end
      end
      S_ALERT2: ctl = '{op: CELL_INSERT, front: 1'b1};
      S_TICK: begin
        if (promote) begin
          ctl.op = CELL_POP;
        end
      end
      default: ;
    endcase
  end

  // ---- control FSM ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      op_q            <= OP_ENQUEUE;
      ent_in_q        <= '0;
      now_q           <= '0;
      limit_q         <= '0;
      status_q        <= ST_NONE;
      count_q         <= '0;
      shown_valid_q   <= 1'b0;
      shown_q         <= '0;
      start_q         <= '0;
      out_valid_q     <= 1'b0;
      out_status_q    <= ST_NONE;
      out_act_valid_q <= 1'b0;
      out_ent_q       <= '0;
      out_count_q     <= '0;
    end else begin
      if (out_o.ready && (state_q != S_RESULT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            op_q     <= in_i.operation;
            ent_in_q <= '{pri: in_i.priority_req, dur: in_dur, tag: in_i.content_tag};
            now_q    <= in_i.now_ms;
            state_q  <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (op_q)
            OP_ENQUEUE: begin
              status_q <= enq_status;
              if (ctl.op == CELL_INSERT) begin
                count_q <= count_q + 1'b1;
              end
              if ((ctl.op == CELL_INSERT) && ctl.front) begin
                shown_valid_q <= 1'b0;
                shown_q       <= '0;
                state_q       <= S_ALERT2;
              end else begin
                state_q <= S_RESULT;
              end
            end
            OP_TICK: begin
              status_q <= ST_NONE;
              limit_q  <= LIMIT_W'(shown_q.dur) * LIMIT_W'(MS_PER_S);
              state_q  <= S_TICK;
            end
            OP_CLEAR: begin
              status_q      <= ST_NONE;
              count_q       <= '0;
              shown_valid_q <= 1'b0;
              shown_q       <= '0;
              state_q       <= S_RESULT;
            end
            default: begin
              status_q <= ST_NONE;
              state_q  <= S_RESULT;
            end
          endcase
        end
        S_ALERT2: begin
          count_q <= count_q + 1'b1;
          state_q <= S_RESULT;
        end
        S_TICK: begin
          if (promote) begin
            shown_q       <= cell_ent[0];
            shown_valid_q <= 1'b1;
            start_q       <= now_q;
            count_q       <= count_q - 1'b1;
          end else if (expired) begin
            shown_valid_q <= 1'b0;
            shown_q       <= '0;
          end
          state_q <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q     <= 1'b1;
            out_status_q    <= status_q;
            out_act_valid_q <= shown_valid_q;
            out_ent_q       <= shown_q;
            out_count_q     <= count_q;
            state_q         <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready              = (state_q == S_IDLE);
  assign out_o.valid             = out_valid_q;
  assign out_o.enqueue_status    = out_status_q;
  assign out_o.active_valid      = out_act_valid_q;
  assign out_o.active_priority   = out_ent_q.pri;
  assign out_o.active_tag        = out_ent_q.tag;
  assign out_o.active_duration_s = out_ent_q.dur;
  assign out_o.queue_count       = out_count_q;

  // ---- assertions ----
`include "priority_notification_queue_assert.svh"

  `PNQ_ASSERT(a_count_bound, count_q <= COUNT_W'(QUEUE_DEPTH))
  `PNQ_ASSERT_IMP(a_idle_slot_zero, !shown_valid_q, shown_q == '0)
  `PNQ_ASSERT_NEXT(a_accept_exec, in_i.valid && in_i.ready, state_q == S_EXEC)
  `PNQ_ASSERT_IMP(a_out_from_result, $rose(out_valid_q), $past(state_q) == S_RESULT)

endmodule

// ===== sv/pnq_cell.sv =====
// One slot of the sorted queue: holds an entry, shifts toward tail on insert, toward head on pop
module pnq_cell import pnq_pkg::*; (
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  logic      occupied_i,
  input  entry_t    new_i,
  input  entry_t    left_i,
  input  logic      left_goes_i,
  input  entry_t    right_i,
  output entry_t    ent_o,
  output logic      goes_o
);

  entry_t ent_q, ent_d;

  // Queue is sorted, so goes is monotonic along the chain: the first cell that
  // goes takes the new entry, every later one takes its left neighbor.
  assign goes_o = ctl_i.front | ~occupied_i | (ent_q.pri < new_i.pri);

  always_comb begin
    ent_d = ent_q;
    case (ctl_i.op)
      CELL_INSERT: begin
        if (left_goes_i) begin
          ent_d = left_i;
        end else if (goes_o) begin
          ent_d = new_i;
        end
      end
      CELL_POP: ent_d = right_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

// ===== bench/priority_notification_queue_scoreboard.sv =====
// Scoreboard for the priority notification queue: predicts every status word and checks it
module priority_notification_queue_scoreboard import pnq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  pnq_in_if           cmd_if,
  pnq_out_if          status_if,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  typedef struct packed {
    logic [1:0]           status;
    logic                 active;
    logic [1:0]           pri;
    logic [TAG_WIDTH-1:0] tag;
    logic [6:0]           dur;
    logic [COUNT_W-1:0]   count;
  } status_word_t;

  // predicted queue contents, head at index 0
  entry_t       waiting_q [QUEUE_DEPTH];
  int           waiting_n;
  logic         shown_on;
  entry_t       shown;
  logic [31:0]  shown_start;

  status_word_t expected_words [$];
  status_word_t want_word;

  function automatic logic [1:0] enqueue_entry(entry_t e);
    bit higher;
    int pos;
    higher = shown_on && (shown.pri != PRI_AMBIENT);
    pos    = waiting_n;
    if (e.pri == PRI_AMBIENT) begin
      for (int i = 0; i < waiting_n; i++)
        if (waiting_q[i].pri != PRI_AMBIENT) higher = 1'b1;
      if (higher) return ST_DROPPED;
    end
    if (e.pri == PRI_ALERT) begin
      if (waiting_n + 2 > QUEUE_DEPTH) return ST_FULL;
      for (int i = waiting_n - 1; i >= 0; i--) waiting_q[i + 2] = waiting_q[i];
      waiting_q[0] = e;
      waiting_q[1] = e;
      waiting_n += 2;
      shown_on = 1'b0;
      shown    = '0;
      return ST_QUEUED;
    end
    if (waiting_n >= QUEUE_DEPTH) return ST_FULL;
    // lands behind every entry of equal or higher priority
    for (int i = 0; i < waiting_n; i++) begin
      if (waiting_q[i].pri < e.pri) begin
        pos = i;
        break;
      end
    end
    for (int i = waiting_n - 1; i >= pos; i--) waiting_q[i + 1] = waiting_q[i];
    waiting_q[pos] = e;
    waiting_n++;
    return ST_QUEUED;
  endfunction

  function automatic void tick_at(logic [31:0] now);
    logic [31:0] elapsed;
    logic [31:0] limit_ms;
    elapsed  = now - shown_start;
    limit_ms = 32'(shown.dur) * 32'(MS_PER_S);
    if (shown_on && elapsed >= limit_ms) begin
      shown_on = 1'b0;
      shown    = '0;
    end
    if (!shown_on && waiting_n > 0) begin
      shown = waiting_q[0];
      for (int i = 1; i < waiting_n; i++) waiting_q[i - 1] = waiting_q[i];
      waiting_n--;
      shown_on    = 1'b1;
      shown_start = now;
    end
  endfunction

  function automatic status_word_t apply_command(logic [1:0] op, logic [1:0] pri,
                                                 logic [7:0] dur_s,
                                                 logic [TAG_WIDTH-1:0] tag,
                                                 logic [31:0] now);
    entry_t       e;
    status_word_t w;
    w.status = ST_NONE;
    case (op)
      OP_ENQUEUE: begin
        e.pri    = pri;
        e.dur    = (dur_s > MAX_DUR_S) ? MAX_DUR_S[6:0] : dur_s[6:0];
        e.tag    = tag;
        w.status = enqueue_entry(e);
      end
      OP_TICK: tick_at(now);
      OP_CLEAR: begin
        waiting_n = 0;
        shown_on  = 1'b0;
        shown     = '0;
      end
      default: ;
    endcase
    w.active = shown_on;
    w.pri    = shown_on ? shown.pri : '0;
    w.tag    = shown_on ? shown.tag : '0;
    w.dur    = shown_on ? shown.dur : '0;
    w.count  = COUNT_W'(waiting_n);
    return w;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      if (fail_count_o < 10)
        $display("[%0t] status word %0d: %s expected %0d, got %0d",
                 $realtime, checked_o, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      fail_count_o = 0;
      checked_o    = 0;
      waiting_n    = 0;
      shown_on     = 1'b0;
      shown        = '0;
      shown_start  = '0;
      expected_words.delete();
    end else begin
      if (status_if.valid && status_if.ready) begin
        if (expected_words.size() == 0) begin
          if (fail_count_o < 10)
            $display("[%0t] status word with no command waiting: count %0d active %0b",
                     $realtime, status_if.queue_count, status_if.active_valid);
          fail_count_o++;
        end else begin
          want_word = expected_words[0];
          expected_words.delete(0);
          check_field("enqueue_status", 32'(want_word.status),
                      32'(status_if.enqueue_status));
          check_field("active_valid", 32'(want_word.active), 32'(status_if.active_valid));
          check_field("active_priority", 32'(want_word.pri),
                      32'(status_if.active_priority));
          check_field("active_tag", 32'(want_word.tag), 32'(status_if.active_tag));
          check_field("active_duration_s", 32'(want_word.dur),
                      32'(status_if.active_duration_s));
          check_field("queue_count", 32'(want_word.count), 32'(status_if.queue_count));
          checked_o++;
        end
      end
      if (cmd_if.valid && cmd_if.ready)
        expected_words.push_back(apply_command(cmd_if.operation, cmd_if.priority_req,
                                               cmd_if.duration_s, cmd_if.content_tag,
                                               cmd_if.now_ms));
    end
    pending_o = expected_words.size();
  end

endmodule

// ===== bench/priority_notification_queue_tb.sv =====
// Top of the priority notification queue testbench: clock, reset, stimulus and verdict
module priority_notification_queue_tb;
  import pnq_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] PRI_LOW     = 2'd1;
  localparam logic [1:0] PRI_MID     = 2'd2;
  localparam int         RANDOM_WORDS = 1750;
  localparam int         BLOCK_WORDS  = 64;
  localparam int         CYCLE_LIMIT  = 1000000;
  localparam int         TAIL_CYCLES  = 20;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned cycle_count;
  int unsigned op_seen [4];
  logic [31:0] clock_ms;
  bit          send_calm;
  bit          recv_calm;

  pnq_in_if  cmd_if ();
  pnq_out_if status_if ();

  priority_notification_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (status_if)
  );

  priority_notification_queue_scoreboard scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_if       (cmd_if),
    .status_if    (status_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL priority_notification_queue");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver stalls, with calm stretches where ready stays up
  initial begin
    int stall_len;
    status_if.ready <= 1'b0;
    recv_calm = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 19) == 0) recv_calm = ~recv_calm;
      stall_len = recv_calm ? 0 : pick_gap();
      if (stall_len > 0) begin
        status_if.ready <= 1'b0;
        repeat (stall_len) @(posedge clk_i);
      end
      status_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  task automatic send_word(logic [1:0] op, logic [1:0] pri, logic [7:0] dur_s,
                           logic [TAG_WIDTH-1:0] tag, logic [31:0] now);
    int gap;
    gap = send_calm ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.operation    <= op;
    cmd_if.priority_req <= pri;
    cmd_if.duration_s   <= dur_s;
    cmd_if.content_tag  <= tag;
    cmd_if.now_ms       <= now;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    op_seen[op]++;
  endtask

  task automatic enqueue(logic [1:0] pri, logic [7:0] dur_s, logic [TAG_WIDTH-1:0] tag);
    send_word(OP_ENQUEUE, pri, dur_s, tag, $urandom);
  endtask

  task automatic tick(logic [31:0] now);
    send_word(OP_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
              TAG_WIDTH'($urandom), now);
  endtask

  task automatic random_tick();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)      clock_ms += $urandom_range(0, 3000);
    else if (r < 88) clock_ms += $urandom_range(3000, 130000);
    else if (r < 95) clock_ms = $urandom;
    else             clock_ms -= $urandom_range(1, 2000);  // time steps back, wraps
    tick(clock_ms);
  endtask

  task automatic random_enqueue();
    int          r;
    logic [1:0]  pri;
    logic [7:0]  dur_s;
    r = $urandom_range(0, 99);
    if (r < 15)      pri = PRI_AMBIENT;
    else if (r < 50) pri = PRI_LOW;
    else if (r < 85) pri = PRI_MID;
    else             pri = PRI_ALERT;
    r = $urandom_range(0, 99);
    if (r < 60)      dur_s = 8'($urandom_range(0, 4));
    else if (r < 80) dur_s = 8'($urandom_range(5, 30));
    else if (r < 90) dur_s = 8'($urandom_range(100, 140));
    else             dur_s = 8'($urandom_range(0, 255));
    enqueue(pri, dur_s, TAG_WIDTH'($urandom));
  endtask

  initial begin
    int enq_weight;
    int r;
    rst_ni              <= 1'b0;
    cmd_if.valid        <= 1'b0;
    cmd_if.operation    <= OP_ENQUEUE;
    cmd_if.priority_req <= PRI_AMBIENT;
    cmd_if.duration_s   <= '0;
    cmd_if.content_tag  <= '0;
    cmd_if.now_ms       <= '0;
    op_seen   = '{default: 0};
    send_calm = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    tick(32'd0);                                   // nothing to promote
    enqueue(PRI_AMBIENT, 8'd0, 16'h0000);
    enqueue(PRI_LOW, 8'd255, 16'hFFFF);            // duration saturates
    enqueue(PRI_MID, 8'd120, 16'h1234);
    send_word(OP_UNUSED, PRI_ALERT, 8'd255, 16'hFFFF, 32'hFFFF_FFFF);
    tick(32'hFFFF_FF00);                           // mid promoted just before wrap
    tick(32'h0001_D3BF);                           // one ms short of 120 s across the wrap
    tick(32'h0001_D3C0);                           // expires, low promoted
    enqueue(PRI_ALERT, 8'd7, 16'hA5A5);            // two copies up front, active cleared
    tick(32'd5);
    for (int i = 0; i < 13; i++)
      enqueue((i % 2) ? PRI_LOW : PRI_MID, 8'(i), 16'(i));
    enqueue(PRI_ALERT, 8'd3, 16'h5A5A);            // one slot left, alert rejected
    enqueue(PRI_MID, 8'd1, 16'h00FF);              // fills the last slot
    enqueue(PRI_LOW, 8'd1, 16'hFF00);              // full
    enqueue(PRI_AMBIENT, 8'd1, 16'h0F0F);          // dropped before the full check
    send_word(OP_CLEAR, PRI_AMBIENT, 8'd0, 16'h0000, 32'd0);

    // random part, operation mix changes per block
    clock_ms   = 32'hFFF0_0000 + $urandom_range(0, 32'hFFFF);
    enq_weight = 50;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % BLOCK_WORDS == 0) begin
        r          = $urandom_range(0, 2);
        enq_weight = (r == 0) ? 35 : (r == 1) ? 55 : 75;
        send_calm  = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < enq_weight)      random_enqueue();
      else if (r < 94)         random_tick();
      else if (r < 97)
        send_word(OP_CLEAR, 2'($urandom_range(0, 3)), 8'($urandom),
                  TAG_WIDTH'($urandom), $urandom);
      else
        send_word(OP_UNUSED, 2'($urandom_range(0, 3)), 8'($urandom),
                  TAG_WIDTH'($urandom), $urandom);
    end
    cmd_if.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d commands: %0d enqueues, %0d ticks, %0d clears, %0d unused codes.",
             op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3],
             op_seen[OP_ENQUEUE], op_seen[OP_TICK], op_seen[OP_CLEAR], op_seen[OP_UNUSED]);
    $display("Checked %0d status words, %0d field mismatches.", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS priority_notification_queue");
    end else begin
      $display("FAIL priority_notification_queue");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/pnq_pkg.sv
sv/pnq_in_if.sv
sv/pnq_out_if.sv
sv/pnq_cell.sv
sv/priority_notification_queue.sv
bench/priority_notification_queue_scoreboard.sv
bench/priority_notification_queue_tb.sv
